// ----- sv/cpg_pkg.sv -----
// ----------------------------------------------------------------------------
// cpg_pkg
// Shared types and constants for the circle point generator.
// ----------------------------------------------------------------------------
package cpg_pkg;
    localparam int MAX_POINTS_DEF = 64;
    localparam int FULL_TURN      = 23040;
    localparam int QUARTER_TURN   = 5760;
    localparam int CORDIC_STEPS   = 18;
    localparam int CORDIC_GAIN    = 652032874;
    localparam int CFG_IDX_W      = 8;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 8'd1;

    typedef struct packed {
        logic load;       // latch request
        logic div_start;  // begin angle division for current index
        logic trig_start; // begin fold and cordic
        logic emit;       // present result
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic trig_done;
        logic last;       // index has reached count: every point emitted
        logic empty;      // count is zero
    } t_status;

    function automatic logic [23:0] atan_lut(input logic [4:0] k);
        logic [23:0] v;
        case (k)
            5'd0:    v = 24'd11796480;
            5'd1:    v = 24'd6963869;
            5'd2:    v = 24'd3679517;
            5'd3:    v = 24'd1867780;
            5'd4:    v = 24'd937515;
            5'd5:    v = 24'd469214;
            5'd6:    v = 24'd234664;
            5'd7:    v = 24'd117339;
            5'd8:    v = 24'd58671;
            5'd9:    v = 24'd29335;
            5'd10:   v = 24'd14668;
            5'd11:   v = 24'd7334;
            5'd12:   v = 24'd3667;
            5'd13:   v = 24'd1833;
            5'd14:   v = 24'd917;
            5'd15:   v = 24'd458;
            5'd16:   v = 24'd229;
            5'd17:   v = 24'd115;
            default: v = 24'd0;
        endcase
        return v;
    endfunction
endpackage

// ----- sv/cpg_ctrl.sv -----
// ----------------------------------------------------------------------------
// cpg_ctrl
// Sequencer: latch, divide, rotate, emit, repeat per point.
// ----------------------------------------------------------------------------
module cpg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  cpg_pkg::t_status i_status,
    output cpg_pkg::t_cmd    o_cmd,
    output logic             o_busy
);
    import cpg_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_CHECK, S_DIV, S_TRIG, S_EMIT} t_state;

    t_state r_state;

    always_comb begin
        o_cmd            = '0;
        o_cmd.load       = (r_state == S_IDLE) && i_start;
        o_cmd.div_start  = (r_state == S_CHECK) && !i_status.empty;
        o_cmd.trig_start = (r_state == S_DIV) && i_status.div_done;
        o_cmd.emit       = (r_state == S_TRIG) && i_status.trig_done;
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE:  if (i_start) r_state <= S_CHECK;
                S_CHECK: r_state <= i_status.empty ? S_IDLE : S_DIV;
                S_DIV:   if (i_status.div_done) r_state <= S_TRIG;
                S_TRIG:  if (i_status.trig_done) r_state <= S_EMIT;
                S_EMIT:  r_state <= i_status.last ? S_IDLE : S_CHECK;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- sv/cpg_datapath.sv -----
// ----------------------------------------------------------------------------
// cpg_datapath
// Request registers, restoring angle divider, quadrant fold, CORDIC,
// radius scaling and result registers.
// ----------------------------------------------------------------------------
module cpg_datapath #(
    parameter int MAX_POINTS = cpg_pkg::MAX_POINTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cpg_pkg::t_cmd       i_cmd,
    output cpg_pkg::t_status    o_status,
    input  logic [6:0]          i_point_count,
    input  logic [9:0]          i_circle_radius,
    input  logic [14:0]         i_first_angle,
    input  logic [9:0]          i_center_x,
    input  logic [9:0]          i_center_y,
    output logic                o_result_valid,
    output logic signed [11:0]  o_point_x,
    output logic signed [11:0]  o_point_y,
    output logic [15:0]         o_point_angle,
    output logic                o_is_last
);
    import cpg_pkg::*;

    localparam logic [6:0] MAXP = 7'(MAX_POINTS);

    logic [6:0]  r_count, r_index;
    logic [9:0]  r_radius;
    logic [14:0] r_start;

    // divider: (index*23040)/count, 21-bit dividend
    logic [20:0] r_quot, r_divq;
    logic [6:0]  r_rem;
    logic [4:0]  r_dbit;
    logic        r_dbusy, r_ddone;
    logic [7:0]  w_trial;

    // trig
    logic [15:0] r_ang;
    logic [15:0] r_ang_out;
    logic [1:0]  r_quad;
    logic [12:0] r_resid;
    logic signed [33:0] r_x, r_y;
    logic signed [26:0] r_z;
    logic [4:0]  r_k;
    logic [2:0]  r_tph;
    logic        r_tbusy, r_tdone;
    logic signed [22:0] r_c, r_s;
    logic signed [33:0] r_pc, r_ps;

    logic [6:0]  w_cnt_sat;
    logic signed [33:0] w_dx, w_dy;
    logic signed [33:0] w_pct, w_pst;
    logic signed [11:0] w_ox, w_oy;

    assign w_cnt_sat = (i_point_count > MAXP) ? MAXP : i_point_count;
    assign w_trial   = {r_rem, r_divq[20]} - {1'b0, r_count};
    assign w_dx      = r_x >>> r_k;
    assign w_dy      = r_y >>> r_k;
    assign w_pct     = (r_pc < 0) ? -((-r_pc) >>> 20) : (r_pc >>> 20);
    assign w_pst     = (r_ps < 0) ? -((-r_ps) >>> 20) : (r_ps >>> 20);

    always_comb begin
        case (r_quad)
            2'd0:    begin w_ox = 12'(w_pct);  w_oy = 12'(w_pst);  end
            2'd1:    begin w_ox = -12'(w_pst); w_oy = 12'(w_pct);  end
            2'd2:    begin w_ox = -12'(w_pct); w_oy = -12'(w_pst); end
            default: begin w_ox = 12'(w_pst);  w_oy = -12'(w_pct); end
        endcase
    end

    assign o_status.div_done  = r_ddone;
    assign o_status.trig_done = r_tdone;
    assign o_status.last      = (r_index == r_count);
    assign o_status.empty     = (r_count == 7'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0; r_index <= '0; r_radius <= '0; r_start <= '0;
            r_dbusy <= 1'b0; r_ddone <= 1'b0; r_tbusy <= 1'b0; r_tdone <= 1'b0;
            o_result_valid <= 1'b0;
        end else begin
            r_ddone <= 1'b0;
            r_tdone <= 1'b0;
            o_result_valid <= 1'b0;
            if (i_cmd.load) begin
                r_count <= w_cnt_sat; r_radius <= i_circle_radius;
                r_start <= i_first_angle; r_index <= '0;
            end
            if (i_cmd.div_start) begin
                r_divq  <= 21'(r_index) * 21'd23040;
                r_rem   <= '0;
                r_dbit  <= '0;
                r_dbusy <= 1'b1;
            end else if (r_dbusy) begin
                if (!w_trial[7]) begin
                    r_rem <= w_trial[6:0]; r_quot <= {r_quot[19:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[5:0], r_divq[20]}; r_quot <= {r_quot[19:0], 1'b0};
                end
                r_divq <= {r_divq[19:0], 1'b0};
                r_dbit <= r_dbit + 5'd1;
                if (r_dbit == 5'd20) begin
                    r_dbusy <= 1'b0; r_ddone <= 1'b1;
                end
            end
            if (i_cmd.trig_start) begin
                r_ang   <= 16'(r_start) + 16'(r_quot);
                r_tph   <= 3'd0;
                r_tbusy <= 1'b1;
            end else if (r_tbusy) begin
                case (r_tph)
                    3'd0: begin
                        if (r_ang >= 16'(2*FULL_TURN))
                            r_ang <= r_ang - 16'(2*FULL_TURN);
                        else if (r_ang >= 16'(FULL_TURN))
                            r_ang <= r_ang - 16'(FULL_TURN);
                        r_tph <= 3'd1;
                    end
                    3'd1: begin
                        if (r_ang >= 16'(3*QUARTER_TURN)) begin
                            r_quad <= 2'd3; r_resid <= 13'(r_ang - 16'(3*QUARTER_TURN));
                        end else if (r_ang >= 16'(2*QUARTER_TURN)) begin
                            r_quad <= 2'd2; r_resid <= 13'(r_ang - 16'(2*QUARTER_TURN));
                        end else if (r_ang >= 16'(QUARTER_TURN)) begin
                            r_quad <= 2'd1; r_resid <= 13'(r_ang - 16'(QUARTER_TURN));
                        end else begin
                            r_quad <= 2'd0; r_resid <= 13'(r_ang);
                        end
                        r_tph <= 3'd2;
                    end
                    3'd2: begin
                        r_x <= 34'sd652032874; r_y <= '0;
                        r_z <= $signed({2'b00, r_resid, 12'd0});
                        r_k <= '0; r_tph <= 3'd3;
                    end
                    3'd3: begin
                        if (!r_z[26]) begin
                            r_x <= r_x - w_dy; r_y <= r_y + w_dx;
                            r_z <= r_z - $signed({3'b000, atan_lut(r_k)});
                        end else begin
                            r_x <= r_x + w_dy; r_y <= r_y - w_dx;
                            r_z <= r_z + $signed({3'b000, atan_lut(r_k)});
                        end
                        r_k <= r_k + 5'd1;
                        if (r_k == 5'(CORDIC_STEPS-1)) r_tph <= 3'd4;
                    end
                    3'd4: begin
                        r_c <= 23'((r_x + 34'sd512) >>> 10);
                        r_s <= 23'((r_y + 34'sd512) >>> 10);
                        r_tph <= 3'd5;
                    end
                    3'd5: begin
                        r_pc <= 34'(r_c * $signed({1'b0, r_radius}));
                        r_ps <= 34'(r_s * $signed({1'b0, r_radius}));
                        r_tph <= 3'd6;
                    end
                    default: begin
                        r_tbusy <= 1'b0; r_tdone <= 1'b1;
                    end
                endcase
            end
            if (i_cmd.emit) begin
                o_result_valid <= 1'b1;
                o_point_x      <= $signed({2'b00, i_center_x}) + w_ox;
                o_point_y      <= $signed({2'b00, i_center_y}) + w_oy;
                o_point_angle  <= r_ang_out;
                o_is_last      <= (r_index + 7'd1 == r_count);
                r_index        <= r_index + 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.trig_start) r_ang_out <= 16'(r_start) + 16'(r_quot);
    end
endmodule

// ----- sv/circle_point_generator_top.sv -----
// ----------------------------------------------------------------------------
// circle_point_generator_top
// Points are computed one at a time: 21 divide steps, quadrant fold, 18 CORDIC
// steps and radius scaling per point. Busy stays high until the last point of
// a request has been strobed (for a zero count, only through the count check);
// the next request is taken once busy falls. Results are strobed for one cycle
// each; the receiver cannot stall.
// Synchronous active-low reset; centre registers reset to 120.
// ----------------------------------------------------------------------------
module circle_point_generator_top #(
    parameter int MAX_POINTS = cpg_pkg::MAX_POINTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [6:0]          i_point_count,
    input  logic [9:0]          i_circle_radius,
    input  logic [14:0]         i_first_angle,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [cpg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    output logic                o_result_valid,
    output logic signed [11:0]  o_point_x,
    output logic signed [11:0]  o_point_y,
    output logic [15:0]         o_point_angle,
    output logic                o_is_last
);
    import cpg_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic [9:0] r_center_x, r_center_y;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= 10'd120;
            r_center_y <= 10'd120;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_CENTER_X) r_center_x <= i_cfg_data[9:0];
            if (i_cfg_index == REG_CENTER_Y) r_center_y <= i_cfg_data[9:0];
        end
    end

    cpg_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_status(w_status), .o_cmd(w_cmd), .o_busy(busy)
    );

    cpg_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_status(w_status),
        .i_point_count(i_point_count), .i_circle_radius(i_circle_radius),
        .i_first_angle(i_first_angle), .i_center_x(r_center_x),
        .i_center_y(r_center_y), .o_result_valid(o_result_valid),
        .o_point_x(o_point_x), .o_point_y(o_point_y),
        .o_point_angle(o_point_angle), .o_is_last(o_is_last)
    );

    a_no_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy)) else $error("result while idle");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_is_last) |=> !o_result_valid) else $error("beat after last");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("start not taken");
endmodule

// ----- tb/tb_circle_point_generator_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circle_point_generator_top
// Drives point requests and centre writes into the circle point generator,
// predicts every point with a bit-exact CORDIC model and checks each strobed
// point in order against the predicted stream.
// ----------------------------------------------------------------------------
module tb_circle_point_generator_top;
    import cpg_pkg::*;

    typedef struct {
        logic [6:0]  count;
        logic [9:0]  radius;
        logic [14:0] angle;
        int          gap;
        bit          drain;
    } t_request;

    typedef struct {
        logic [11:0] x;
        logic [11:0] y;
        logic [15:0] angle;
        logic        last;
    } t_point;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [6:0]  i_point_count = '0;
    logic [9:0]  i_circle_radius = '0;
    logic [14:0] i_first_angle = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        o_result_valid;
    logic signed [11:0] o_point_x;
    logic signed [11:0] o_point_y;
    logic [15:0] o_point_angle;
    logic        o_is_last;

    circle_point_generator_top uut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_request pending_reqs[$];
    t_point   expected_points[$];
    int       error_count = 0;
    bit       stim_done = 0;
    logic [9:0] centre_x = 10'd120;
    logic [9:0] centre_y = 10'd120;
    int       atan_steps[CORDIC_STEPS] = '{11796480, 6963869, 3679517, 1867780, 937515,
        469214, 234664, 117339, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

    // truncating shift toward zero: >>> on signed longint is arithmetic
    function automatic longint trunc20(longint v);
        return (v >= 0) ? (v >>> 20) : -((-v) >>> 20);
    endfunction

    function automatic void rotate_offset(int unsigned ang, int unsigned r,
                                          output longint dx, output longint dy);
        int unsigned a;
        int unsigned quad;
        longint x, y, z, tx, c, s, pc, ps;
        a = ang % FULL_TURN;
        quad = a / QUARTER_TURN;
        x = CORDIC_GAIN;
        y = 0;
        z = longint'(a % QUARTER_TURN) * 4096;
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            tx = x;
            if (z >= 0) begin
                x = x - (y >>> k); y = y + (tx >>> k); z = z - atan_steps[k];
            end else begin
                x = x + (y >>> k); y = y - (tx >>> k); z = z + atan_steps[k];
            end
        end
        c = (x + 512) >>> 10;
        s = (y + 512) >>> 10;
        pc = trunc20(longint'(r) * c);
        ps = trunc20(longint'(r) * s);
        case (quad)
            0: begin dx = pc;  dy = ps;  end
            1: begin dx = -ps; dy = pc;  end
            2: begin dx = -pc; dy = -ps; end
            default: begin dx = ps; dy = -pc; end
        endcase
    endfunction

    function automatic void predict_points(t_request q);
        int unsigned n, ang;
        longint dx, dy;
        t_point p;
        n = (q.count > MAX_POINTS_DEF) ? MAX_POINTS_DEF : q.count;
        for (int unsigned i = 0; i < n; i++) begin
            ang = q.angle + (i * FULL_TURN) / n;
            rotate_offset(ang, q.radius, dx, dy);
            p.x = 12'(longint'(centre_x) + dx);
            p.y = 12'(longint'(centre_y) + dy);
            p.angle = 16'(ang);
            p.last = (i + 1 == n);
            expected_points = {expected_points, p};
        end
    endfunction

    // driver
    int gap_left = 0;
    bit holding = 0;
    bit busy_at_edge = 1'b1;
    t_request cur;
    always @(negedge i_clk) begin
        if (i_rst_n && !stim_done) begin
            if (start && !busy_at_edge) begin
                // beat taken at the last rising edge
                holding = 0;
            end
            if (!holding && pending_reqs.size() > 0) begin
                cur = pending_reqs.pop_front();
                gap_left = cur.gap;
                holding = 1;
            end
            if (holding && cur.drain && expected_points.size() != 0) begin
                start <= 1'b0;
            end else if (holding && gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (holding) begin
                start <= 1'b1;
                i_point_count <= cur.count;
                i_circle_radius <= cur.radius;
                i_first_angle <= cur.angle;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        busy_at_edge <= busy;
        if (i_rst_n && start && !busy)
            predict_points(cur);
    end

    // monitor
    always @(posedge i_clk) begin
        t_point e;
        if (i_rst_n && o_result_valid) begin
            if (expected_points.size() == 0) begin
                $error("unexpected point x=%0d y=%0d", o_point_x, o_point_y);
                error_count++;
            end else begin
                e = expected_points.pop_front();
                if (o_point_x !== e.x) begin
                    $error("point_x exp %0d got %0d", $signed(e.x), o_point_x); error_count++;
                end
                if (o_point_y !== e.y) begin
                    $error("point_y exp %0d got %0d", $signed(e.y), o_point_y); error_count++;
                end
                if (o_point_angle !== e.angle) begin
                    $error("point_angle exp %0d got %0d", e.angle, o_point_angle);
                    error_count++;
                end
                if (o_is_last !== e.last) begin
                    $error("is_last exp %0d got %0d", e.last, o_is_last); error_count++;
                end
            end
        end
    end

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || holding || start || expected_points.size() != 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_centre(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == REG_CENTER_X) centre_x = val[9:0];
        else if (idx == REG_CENTER_Y) centre_y = val[9:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic add_request(int c, int r, int a, bit drain = 0);
        t_request q;
        q.count = 7'(c); q.radius = 10'(r); q.angle = 15'(a);
        q.gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
        q.drain = drain;
        pending_reqs = {pending_reqs, q};
    endtask

    task automatic random_phase(int items);
        int sel;
        for (int i = 0; i < items; i++) begin
            sel = $urandom_range(0, 9);
            if (sel < 6)
                add_request($urandom_range(1, 12), $urandom_range(0, 1023),
                            $urandom_range(0, 23039), $urandom_range(0, 30) == 0);
            else if (sel < 8)
                add_request($urandom_range(0, 127), $urandom_range(0, 1023),
                            $urandom_range(0, 32767));
            else
                add_request($urandom_range(0, 3), $urandom, $urandom);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // directed
        add_request(0, 100, 0);
        add_request(1, 0, 0);
        add_request(1, 1023, 0);
        add_request(4, 1023, 0);
        add_request(4, 1023, 5760);
        add_request(3, 1023, 23039);
        add_request(2, 1023, 32767);
        add_request(64, 1023, 1000);
        add_request(127, 500, 11520, 1);
        add_request(65, 1, 17280);
        add_request(7, 682, 21845);
        add_request(0, 0, 0);
        wait_idle();
        write_centre(REG_CENTER_X, 32'd0);
        write_centre(REG_CENTER_Y, 32'd0);
        add_request(8, 1023, 0);
        add_request(5, 1023, 2880);
        random_phase(60);
        wait_idle();
        write_centre(REG_CENTER_X, 32'd1023);
        write_centre(REG_CENTER_Y, 32'hFFFF_FFFF);
        write_centre(8'd2, 32'd55);
        write_centre(8'hFF, 32'd7);
        add_request(8, 1023, 0);
        random_phase(60);
        wait_idle();
        write_centre(REG_CENTER_X, $urandom);
        write_centre(REG_CENTER_Y, $urandom);
        random_phase(135);
        wait_idle();
        stim_done = 1;
        if (error_count == 0)
            $display("tb_circle_point_generator_top: clean");
        else
            $display("tb_circle_point_generator_top: errors");
        $finish;
    end

    initial begin
        #60ms;
        $display("tb_circle_point_generator_top: errors");
        $finish;
    end
endmodule

// ----- circle_point_generator_top.f -----
sv/cpg_pkg.sv
sv/cpg_ctrl.sv
sv/cpg_datapath.sv
sv/circle_point_generator_top.sv
tb/tb_circle_point_generator_top.sv
